### rtl/rsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

    // Storage widths
    localparam int LENGTH_BITS_DEF = 32;
    localparam int ACC_W           = 32;
    localparam int PROD_W          = ACC_W + 4;
    localparam int COUNT_W         = 32;

    // Type bytes
    localparam logic [7:0] CH_BULK   = 8'h24;  // '$'
    localparam logic [7:0] CH_INT    = 8'h3A;  // ':'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_ARRAY  = 8'h2A;  // '*'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

    // Remaining status bytes after the type byte
    localparam logic [2:0] OK_SKIP   = 3'd4;
    localparam logic [2:0] FAIL_SKIP = 3'd7;

    // Integer magnitude limits
    localparam logic [PROD_W-1:0] INT_POS_MAX = PROD_W'(64'h7FFF_FFFF);
    localparam logic [PROD_W-1:0] INT_NEG_MAX = PROD_W'(64'h8000_0000);

    typedef enum logic [2:0] {
        EV_STR_START = 3'd0,
        EV_PAYLOAD   = 3'd1,
        EV_STR_END   = 3'd2,
        EV_INTEGER   = 3'd3,
        EV_OK        = 3'd4,
        EV_FAIL      = 3'd5,
        EV_ARR_START = 3'd6,
        EV_FORMAT    = 3'd7
    } event_t;

    // One digit step of a decimal run
    typedef struct packed {
        logic             is_digit;
        logic             overflow;
        logic [ACC_W-1:0] value;
    } digit_res_t;

    // One result beat
    typedef struct packed {
        event_t             ev;
        logic [7:0]         data;
        logic [COUNT_W-1:0] count;
        logic [31:0]        ival;
        logic               last;
    } out_beat_t;

endpackage

`default_nettype wire

### rtl/rsd_digit_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_digit_acc
    import rsd_pkg::*;
(
    input  wire logic [ACC_W-1:0]  acc,
    input  wire logic [7:0]        in_byte,
    input  wire logic [PROD_W-1:0] limit,
    output digit_res_t             res
);

    logic [7:0]        diff;
    logic [PROD_W-1:0] wide;
    logic [PROD_W-1:0] prod;

    // acc * 10 + digit as two shifts and adds
    assign diff = in_byte - CH_ZERO;
    assign wide = PROD_W'(acc);
    assign prod = (wide << 3) + (wide << 1) + PROD_W'(diff[3:0]);

    assign res.is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign res.overflow = prod > limit;
    assign res.value    = prod[ACC_W-1:0];

endmodule

`default_nettype wire

### rtl/rsd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_core
    import rsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_take,
    input  wire logic [7:0] in_byte,
    output logic            res_valid,
    output out_beat_t       res
);

    typedef enum logic [12:0] {
        PH_IDLE      = 13'b0000000000001,
        PH_INT_FIRST = 13'b0000000000010,
        PH_INT_DIG   = 13'b0000000000100,
        PH_INT_LF    = 13'b0000000001000,
        PH_BULK_LEN  = 13'b0000000010000,
        PH_BULK_LF   = 13'b0000000100000,
        PH_BULK_DATA = 13'b0000001000000,
        PH_TRAIL1    = 13'b0000010000000,
        PH_TRAIL2    = 13'b0000100000000,
        PH_ARR_CNT   = 13'b0001000000000,
        PH_ARR_LF    = 13'b0010000000000,
        PH_OK        = 13'b0100000000000,
        PH_FAIL      = 13'b1000000000000
    } phase_t;

    localparam logic [PROD_W-1:0] LenMax = PROD_W'({LENGTH_BITS{1'b1}});

    phase_t                 phase_reg, phase_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [2:0]             skip_reg, skip_next;
    logic [LENGTH_BITS-1:0] pay_reg, pay_next;
    logic [LENGTH_BITS-1:0] elem_reg, elem_next;
    logic                   in_arr_reg, in_arr_next;

    logic [PROD_W-1:0]      limit;
    digit_res_t             dig;
    logic [LENGTH_BITS-1:0] acc_len;
    logic [31:0]            ival;
    logic [2:0]             skip_dec;
    logic [LENGTH_BITS-1:0] pay_dec;
    logic [LENGTH_BITS-1:0] elem_dec;
    logic                   fmt_err;

    // Digit limit follows the run being parsed
    always_comb begin
        if (phase_reg == PH_INT_FIRST || phase_reg == PH_INT_DIG) begin
            limit = neg_reg ? INT_NEG_MAX : INT_POS_MAX;
        end else begin
            limit = LenMax;
        end
    end

    rsd_digit_acc u_digit (
        .acc     (acc_reg),
        .in_byte (in_byte),
        .limit   (limit),
        .res     (dig)
    );

    assign acc_len  = LENGTH_BITS'(acc_reg);
    assign ival     = neg_reg ? (32'd0 - 32'(acc_reg)) : 32'(acc_reg);
    assign skip_dec = (skip_reg != 3'd0) ? (skip_reg - 3'd1) : 3'd0;
    assign pay_dec  = pay_reg - LENGTH_BITS'(1);
    assign elem_dec = elem_reg - LENGTH_BITS'(1);

    // Next state and result for one byte
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        skip_next   = skip_reg;
        pay_next    = pay_reg;
        elem_next   = elem_reg;
        in_arr_next = in_arr_reg;
        fmt_err     = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                acc_next = '0;
                neg_next = 1'b0;
                if (in_arr_reg && in_byte != CH_BULK) begin
                    fmt_err = 1'b1;
                end else if (in_byte == CH_BULK) begin
                    phase_next = PH_BULK_LEN;
                end else if (in_byte == CH_INT) begin
                    phase_next = PH_INT_FIRST;
                end else if (in_byte == CH_PLUS) begin
                    skip_next  = OK_SKIP;
                    phase_next = PH_OK;
                end else if (in_byte == CH_MINUS) begin
                    skip_next  = FAIL_SKIP;
                    phase_next = PH_FAIL;
                end else if (in_byte == CH_ARRAY) begin
                    phase_next = PH_ARR_CNT;
                end else begin
                    fmt_err = 1'b1;
                end
            end
            PH_INT_FIRST, PH_INT_DIG: begin
                phase_next = PH_INT_DIG;
                if (phase_reg == PH_INT_FIRST && in_byte == CH_MINUS) begin
                    neg_next = 1'b1;
                end else if (phase_reg == PH_INT_FIRST && in_byte == CH_PLUS) begin
                    neg_next = neg_reg;
                end else if (!dig.is_digit) begin
                    phase_next = PH_INT_LF;
                end else if (dig.overflow) begin
                    fmt_err = 1'b1;
                end else begin
                    acc_next = dig.value;
                end
            end
            PH_INT_LF: begin
                phase_next = PH_IDLE;
                acc_next   = '0;
                neg_next   = 1'b0;
                res_valid  = 1'b1;
                res.ev     = EV_INTEGER;
                res.ival   = ival;
                res.last   = 1'b1;
            end
            PH_BULK_LEN, PH_ARR_CNT: begin
                if (!dig.is_digit) begin
                    phase_next = (phase_reg == PH_BULK_LEN) ? PH_BULK_LF : PH_ARR_LF;
                end else if (dig.overflow) begin
                    fmt_err = 1'b1;
                end else begin
                    acc_next = dig.value;
                end
            end
            PH_BULK_LF: begin
                pay_next   = acc_len;
                acc_next   = '0;
                phase_next = (acc_len != '0) ? PH_BULK_DATA : PH_TRAIL1;
                res_valid  = 1'b1;
                res.ev     = EV_STR_START;
                res.count  = COUNT_W'(acc_len);
            end
            PH_BULK_DATA: begin
                pay_next = pay_dec;
                if (pay_dec == '0) begin
                    phase_next = PH_TRAIL1;
                end
                res_valid = 1'b1;
                res.ev    = EV_PAYLOAD;
                res.data  = in_byte;
            end
            PH_TRAIL1: begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res.ev     = EV_STR_END;
                res.last   = 1'b1;
                if (in_arr_reg) begin
                    elem_next = elem_dec;
                    if (elem_dec == '0) begin
                        in_arr_next = 1'b0;
                    end else begin
                        res.last = 1'b0;
                    end
                end
            end
            PH_ARR_LF: begin
                acc_next    = '0;
                phase_next  = PH_IDLE;
                elem_next   = acc_len;
                in_arr_next = (acc_len != '0);
                res_valid   = 1'b1;
                res.ev      = EV_ARR_START;
                res.count   = COUNT_W'(acc_len);
                res.last    = (acc_len == '0);
            end
            PH_OK, PH_FAIL: begin
                skip_next = skip_dec;
                if (skip_dec == 3'd0) begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res.ev     = (phase_reg == PH_OK) ? EV_OK : EV_FAIL;
                    res.last   = 1'b1;
                end
            end
            default: begin
                fmt_err = 1'b1;
            end
        endcase

        // Format error aborts everything
        if (fmt_err) begin
            phase_next  = PH_IDLE;
            acc_next    = '0;
            neg_next    = 1'b0;
            skip_next   = '0;
            pay_next    = '0;
            elem_next   = '0;
            in_arr_next = 1'b0;
            res_valid   = 1'b1;
            res         = '0;
            res.ev      = EV_FORMAT;
            res.last    = 1'b1;
        end
    end

    // State registers advance on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            skip_reg   <= '0;
            pay_reg    <= '0;
            elem_reg   <= '0;
            in_arr_reg <= 1'b0;
        end else if (in_take) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            skip_reg   <= skip_next;
            pay_reg    <= pay_next;
            elem_reg   <= elem_next;
            in_arr_reg <= in_arr_next;
        end
    end

endmodule

`default_nettype wire

### rtl/resp_stream_decoder_unit.sv
// Channel  Dir  Ports                                        Beat
// -------  ---  -------------------------------------------  --------------------------
// s_       in   s_valid s_ready s_in_byte                    one stream byte
// m_       out  m_valid m_ready m_event_res m_data_byte      one decoded event
//               m_count_value m_integer_value m_message_last
//
// One byte per cycle while s_ready is high; each event leaves the cycle after its byte.
// Parse state and result are updated in the same cycle from the byte and the
// phase register, then held in the output register.
// s_ready stays high while the output register is empty or being taken.
// Synchronous active-low reset returns the parser to waiting for a type byte.
`timescale 1ns / 1ps
`default_nettype none

module resp_stream_decoder_unit
    import rsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_in_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_event_res,
    output logic [7:0]              m_data_byte,
    output logic [COUNT_W-1:0]      m_count_value,
    output logic signed [31:0]      m_integer_value,
    output logic                    m_message_last
);

    logic      take;
    logic      res_valid;
    out_beat_t res;
    logic      m_valid_reg, m_valid_next;
    out_beat_t out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    rsd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (take),
        .in_byte   (s_in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = out_reg.ev;
    assign m_data_byte     = out_reg.data;
    assign m_count_value   = out_reg.count;
    assign m_integer_value = signed'(out_reg.ival);
    assign m_message_last  = out_reg.last;

endmodule

`default_nettype wire
